[rtl/core/signed_gadget_decompose_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed gadget decomposer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_GADGET_DECOMPOSE_ASSERT_SVH
`define SIGNED_GADGET_DECOMPOSE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgd assertion failed");
// Next-cycle implication.
`define SGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgd assertion failed");
`else
`define SGD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/sgd_pkg.sv]
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared widths, register indexes and the pipeline control struct.
// ----------------------------------------------------------------------------
package sgd_pkg;

	localparam int DEF_MAX_LEVELS = 8;

	localparam int COEF_W     = 32;
	localparam int DIGIT_W    = 16;
	localparam int LIDX_W     = 3;
	localparam int BITS_W     = 5;
	localparam int LEVELS_W   = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [BITS_W-1:0] MAX_DIGIT_BITS = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BITS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 4'd1;

	localparam logic [BITS_W-1:0]   RESET_DIGIT_BITS = 5'd10;
	localparam logic [LEVELS_W-1:0] RESET_LEVELS     = 4'd2;

	// Control that travels with an item down the pipeline.
	typedef struct packed {
		logic                valid;
		logic [BITS_W-1:0]   bits;
		logic [LEVELS_W-1:0] count;
	} item_ctl_t;

endpackage

[rtl/core/sgd_channels.sv]
// ----------------------------------------------------------------------------
// sgd channels
// Valid/ready channel interfaces for coefficients, digits and configuration.
// ----------------------------------------------------------------------------
interface sgd_coef_if;
	logic                        valid;
	logic                        ready;
	logic [sgd_pkg::COEF_W-1:0]  coefficient;
	modport source (output valid, output coefficient, input ready);
	modport sink (input valid, input coefficient, output ready);
endinterface

interface sgd_digit_if;
	logic                              valid;
	logic                              ready;
	logic signed [sgd_pkg::DIGIT_W-1:0] digit;
	logic [sgd_pkg::LIDX_W-1:0]        level_index;
	logic                              last;
	modport source (output valid, output digit, output level_index, output last, input ready);
	modport sink (input valid, input digit, input level_index, input last, output ready);
endinterface

interface sgd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sgd_pkg::CFG_IDX_W-1:0]   index;
	logic [sgd_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/signed_gadget_decompose.sv]
// ----------------------------------------------------------------------------
// signed_gadget_decompose
// Signed gadget decomposition of 32-bit torus coefficients into digits.
// ----------------------------------------------------------------------------
// Usage:
//   coef   - valid/ready input, one 32-bit coefficient per item.
//   result - valid/ready output, one signed digit per item, most
//            significant first, with level_index and last on the final one.
//   cfg    - valid/ready register writes, always ready. Index 0 sets
//            digit_bits, index 1 sets levels; other indexes are ignored.
//            Write only while no coefficient is in flight.
// Timing: three pipeline stages (offset add, lane extract, carry/balance)
//   feed a serializer with an output register, and the stages keep taking
//   coefficients while the serializer is busy. Digits leave the output
//   register one per cycle while result.ready is high, and the serializer
//   loads the next vector as it pushes the last digit. Coefficients
//   arriving with levels 0 are taken and produce nothing.
// Reset: arst_n clears all valid bits and loads digit_bits 10, levels 2.
// Stall: when result.ready drops, the output register holds, the
//   serializer and pipeline fill up, and coef.ready falls once every stage
//   is full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "signed_gadget_decompose_assert.svh"

module signed_gadget_decompose #(
	parameter int MAX_LEVELS = sgd_pkg::DEF_MAX_LEVELS
) (
	input  logic        clk,
	input  logic        arst_n,
	sgd_cfg_if.sink     cfg,
	sgd_coef_if.sink    coef,
	sgd_digit_if.source result
);

	logic [sgd_pkg::BITS_W-1:0]                  digit_bits_q;
	logic [sgd_pkg::LEVELS_W-1:0]                levels_q;
	logic [sgd_pkg::BITS_W-1:0]                  bits_eff;
	logic [sgd_pkg::LEVELS_W-1:0]                levels_eff;
	sgd_pkg::item_ctl_t                          in_ctl;
	sgd_pkg::item_ctl_t                          ctl_s2;
	sgd_pkg::item_ctl_t                          ctl_s3;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] raw_s2;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] digits_s3;
	logic                                        ready_s2;
	logic                                        ser_ready;

	// Register writes; unknown indexes drop.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_bits_q <= sgd_pkg::RESET_DIGIT_BITS;
			levels_q     <= sgd_pkg::RESET_LEVELS;
		end else if (cfg.valid) begin
			case (cfg.index)
				sgd_pkg::REG_DIGIT_BITS: digit_bits_q <= cfg.data[sgd_pkg::BITS_W-1:0];
				sgd_pkg::REG_LEVELS:     levels_q     <= cfg.data[sgd_pkg::LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp digit width to 1..16 and level count to MAX_LEVELS.
	always_comb begin
		if (digit_bits_q == '0) begin
			bits_eff = 5'd1;
		end else if (digit_bits_q > sgd_pkg::MAX_DIGIT_BITS) begin
			bits_eff = sgd_pkg::MAX_DIGIT_BITS;
		end else begin
			bits_eff = digit_bits_q;
		end
		if (int'(levels_q) > MAX_LEVELS) begin
			levels_eff = sgd_pkg::LEVELS_W'(MAX_LEVELS);
		end else begin
			levels_eff = levels_q;
		end
	end

	// Items with no levels are taken but never enter the pipeline.
	always_comb begin
		in_ctl.valid = coef.valid && (levels_eff != '0);
		in_ctl.bits  = bits_eff;
		in_ctl.count = levels_eff;
	end

	// Stages 1 and 2: round and cut raw digits.
	sgd_extract #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_extract (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (in_ctl),
		.coefficient (coef.coefficient),
		.in_ready    (coef.ready),
		.out_ctl     (ctl_s2),
		.raw         (raw_s2),
		.out_ready   (ready_s2)
	);

	// Stage 3: resolve carries and balance digits.
	sgd_balance #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_balance (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl_s2),
		.raw       (raw_s2),
		.in_ready  (ready_s2),
		.out_ctl   (ctl_s3),
		.digits    (digits_s3),
		.out_ready (ser_ready)
	);

	// Serialize digits onto the result channel.
	sgd_serialize #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_serialize (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_s3),
		.digits   (digits_s3),
		.in_ready (ser_ready),
		.result   (result)
	);

	// A digit taken that is not the last must be followed by the next one.
	`SGD_ASSERT_NEXT(a_next_digit_follows, clk, arst_n,
		result.valid && result.ready && !result.last, result.valid)
	`SGD_ASSERT_NEXT(a_index_advances, clk, arst_n,
		result.valid && result.ready && !result.last,
		result.level_index == $past(result.level_index) + 3'd1)
	// A stalled stage 3 item holds its digits.
	`SGD_ASSERT_NEXT(a_s3_holds, clk, arst_n,
		ctl_s3.valid && !ser_ready, ctl_s3.valid && $stable(digits_s3))

endmodule

[rtl/core/sgd_extract.sv]
// ----------------------------------------------------------------------------
// sgd_extract
// Stage 1 adds the rounding offset; stage 2 cuts the raw digit lanes.
// ----------------------------------------------------------------------------
module sgd_extract #(
	parameter int MAX_LEVELS = sgd_pkg::DEF_MAX_LEVELS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sgd_pkg::item_ctl_t                           in_ctl,
	input  logic [sgd_pkg::COEF_W-1:0]                   coefficient,
	output logic                                         in_ready,
	output sgd_pkg::item_ctl_t                           out_ctl,
	output logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0]  raw,
	input  logic                                         out_ready
);

	sgd_pkg::item_ctl_t                          ctl_s1;
	sgd_pkg::item_ctl_t                          ctl_s2;
	logic [sgd_pkg::COEF_W-1:0]                  v_s1;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] raw_s2;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] raw_next;
	logic                                        ready_s1;
	logic                                        ready_s2;
	logic [8:0]                                  total;
	logic [sgd_pkg::COEF_W-1:0]                  offset;

	assign ready_s2 = !ctl_s2.valid || out_ready;
	assign ready_s1 = !ctl_s1.valid || ready_s2;
	assign in_ready = ready_s1;

	// Rounding offset: half an LSB of the lowest kept digit.
	always_comb begin
		total = 9'(in_ctl.count) * 9'(in_ctl.bits);
		if (total >= 9'd32) begin
			offset = '0;
		end else begin
			offset = 32'd1 << (5'd31 - total[4:0]);
		end
	end

	// Lane i holds the i-th digit from the top; bits below bit 0 read as zero.
	always_comb begin
		logic [8:0]                 sh;
		logic [sgd_pkg::COEF_W-1:0] w;
		logic [sgd_pkg::DIGIT_W-1:0] top;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			sh = 9'(ctl_s1.bits) * 9'(i);
			if (sh >= 9'd32) begin
				w = '0;
			end else begin
				w = v_s1 << sh[4:0];
			end
			top = w[31:16];
			raw_next[i] = top >> (sgd_pkg::MAX_DIGIT_BITS - ctl_s1.bits);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (ready_s1) begin
				ctl_s1 <= in_ctl;
			end
			if (ready_s2) begin
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			v_s1 <= coefficient + offset;
		end
		if (ready_s2) begin
			raw_s2 <= raw_next;
		end
	end

	assign out_ctl = ctl_s2;
	assign raw     = raw_s2;

endmodule

[rtl/core/sgd_balance.sv]
// ----------------------------------------------------------------------------
// sgd_balance
// Stage 3: carry ripple across lanes and balanced digit formation.
// ----------------------------------------------------------------------------
module sgd_balance #(
	parameter int MAX_LEVELS = sgd_pkg::DEF_MAX_LEVELS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sgd_pkg::item_ctl_t                           in_ctl,
	input  logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0]  raw,
	output logic                                         in_ready,
	output sgd_pkg::item_ctl_t                           out_ctl,
	output logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0]  digits,
	input  logic                                         out_ready
);

	sgd_pkg::item_ctl_t                          ctl_s3;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] digits_s3;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] digits_next;
	logic [MAX_LEVELS-1:0]                       cin;
	logic [3:0]                                  sel;
	logic [sgd_pkg::DIGIT_W-1:0]                 half;
	logic [sgd_pkg::DIGIT_W-1:0]                 mask;

	assign in_ready = !ctl_s3.valid || out_ready;
	assign sel      = 4'(in_ctl.bits - 5'd1);
	assign half     = 16'd1 << sel;
	assign mask     = 16'hFFFF >> (sgd_pkg::MAX_DIGIT_BITS - in_ctl.bits);

	// Carry ripples from the least significant active lane upward:
	// generate when the lane is at least half, propagate at exactly half-1.
	always_comb begin
		logic c;
		c = 1'b0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			cin[i] = c;
			if (i < int'(in_ctl.count)) begin
				c = raw[i][sel] || ((raw[i] == half - 16'd1) && c);
			end
		end
	end

	// Low digit_bits of raw+carry, sign-extended, is the balanced digit.
	always_comb begin
		logic [sgd_pkg::DIGIT_W-1:0] s;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			s = (raw[i] + 16'(cin[i])) & mask;
			if (s[sel]) begin
				s = s | ~mask;
			end
			digits_next[i] = s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (in_ready) begin
			ctl_s3 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			digits_s3 <= digits_next;
		end
	end

	assign out_ctl = ctl_s3;
	assign digits  = digits_s3;

endmodule

[rtl/core/sgd_serialize.sv]
// ----------------------------------------------------------------------------
// sgd_serialize
// Shifts a digit vector out via an output register, one digit per ready cycle.
// ----------------------------------------------------------------------------
module sgd_serialize #(
	parameter int MAX_LEVELS = sgd_pkg::DEF_MAX_LEVELS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sgd_pkg::item_ctl_t                           in_ctl,
	input  logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0]  digits,
	output logic                                         in_ready,
	sgd_digit_if.source                                  result
);

	logic                                        busy_q;
	logic [sgd_pkg::LEVELS_W-1:0]                idx_q;
	logic [sgd_pkg::LEVELS_W-1:0]                cnt_q;
	logic [MAX_LEVELS-1:0][sgd_pkg::DIGIT_W-1:0] buf_q;
	logic                                        valid_q;
	logic [sgd_pkg::DIGIT_W-1:0]                 digit_q;
	logic [sgd_pkg::LIDX_W-1:0]                  lidx_q;
	logic                                        last_q;
	logic                                        out_free;
	logic                                        push;
	logic                                        at_last;
	logic                                        done;
	logic                                        load;

	assign out_free = !valid_q || result.ready;
	assign push     = busy_q && out_free;
	assign at_last  = (idx_q == cnt_q - 4'd1);
	assign done     = push && at_last;
	assign in_ready = !busy_q || done;
	assign load     = in_ctl.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				cnt_q  <= in_ctl.count;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (push) begin
				idx_q <= idx_q + 4'd1;
			end
			if (push) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= digits;
		end else if (push) begin
			for (int k = 0; k < MAX_LEVELS - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
			buf_q[MAX_LEVELS-1] <= '0;
		end
		if (push) begin
			digit_q <= buf_q[0];
			lidx_q  <= idx_q[sgd_pkg::LIDX_W-1:0];
			last_q  <= at_last;
		end
	end

	assign result.valid       = valid_q;
	assign result.digit       = $signed(digit_q);
	assign result.level_index = lidx_q;
	assign result.last        = last_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams torus coefficients through signed_gadget_decompose under a series of
// digit widths and level counts, predicts every balanced digit and compares
// each one against the digit stream as it leaves, with random idling on both
// sides of the block.
// ----------------------------------------------------------------------------

class digit_checker;
	typedef struct {
		logic signed [sgd_pkg::DIGIT_W-1:0] digit;
		logic [sgd_pkg::LIDX_W-1:0]         level_index;
		logic                               last;
	} digit_t;

	logic [sgd_pkg::BITS_W-1:0]   digit_bits;
	logic [sgd_pkg::LEVELS_W-1:0] levels;
	digit_t                       predicted_digits[$];
	int                           errors;

	function new();
		digit_bits = sgd_pkg::RESET_DIGIT_BITS;
		levels     = sgd_pkg::RESET_LEVELS;
		errors     = 0;
	endfunction

	// Mirror a register write; unmapped indexes leave both registers alone.
	function void write_reg(logic [sgd_pkg::CFG_IDX_W-1:0] index,
			logic [sgd_pkg::CFG_DATA_W-1:0] data);
		case (index)
			sgd_pkg::REG_DIGIT_BITS: begin
				digit_bits = data[sgd_pkg::BITS_W-1:0];
			end
			sgd_pkg::REG_LEVELS: begin
				levels = data[sgd_pkg::LEVELS_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Round, cut into lanes and balance from the bottom lane up.
	function void note_coefficient(logic [sgd_pkg::COEF_W-1:0] coefficient);
		int unsigned                 b, n, total, base, half, carry, lane, d;
		int                          lo;
		logic [63:0]                 wide;
		int                          balanced [sgd_pkg::DEF_MAX_LEVELS];
		digit_t                      e;
		b = digit_bits;
		if (b < 1)
			b = 1;
		else if (b > sgd_pkg::MAX_DIGIT_BITS)
			b = sgd_pkg::MAX_DIGIT_BITS;
		n = levels;
		if (n > sgd_pkg::DEF_MAX_LEVELS)
			n = sgd_pkg::DEF_MAX_LEVELS;
		total = n * b;
		wide = {32'd0, coefficient + ((total >= 32) ? 32'd0 : (32'd1 << (31 - total)))};
		base = 1 << b;
		half = base >> 1;
		carry = 0;
		for (int i = int'(n) - 1; i >= 0; i--) begin
			lo = 32 - int'(b) * (i + 1);
			// lanes that run below bit 0 read zeros there
			if (lo + int'(b) <= 0)
				lane = 0;
			else if (lo >= 0)
				lane = 32'(wide >> lo) & (base - 1);
			else
				lane = 32'(wide << (-lo)) & (base - 1);
			d = lane + carry;
			if (d >= half) begin
				balanced[i] = int'(d) - int'(base);
				carry = 1;
			end else begin
				balanced[i] = int'(d);
				carry = 0;
			end
		end
		for (int i = 0; i < int'(n); i++) begin
			e.digit       = balanced[i][15:0];
			e.level_index = i[2:0];
			e.last        = (i == int'(n) - 1);
			predicted_digits.push_back(e);
		end
	endfunction

	function void check_digit(logic signed [sgd_pkg::DIGIT_W-1:0] digit,
			logic [sgd_pkg::LIDX_W-1:0] level_index, logic last);
		digit_t e;
		if (predicted_digits.size() == 0) begin
			$display("%0t: unexpected item digit %0d level_index %0d last %0b",
				$time, digit, level_index, last);
			errors++;
			return;
		end
		e = predicted_digits.pop_front();
		if (digit !== e.digit) begin
			$display("%0t: digit expected %0d actual %0d", $time, e.digit, digit);
			errors++;
		end
		if (level_index !== e.level_index) begin
			$display("%0t: level_index expected %0d actual %0d",
				$time, e.level_index, level_index);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: last expected %0b actual %0b", $time, e.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return predicted_digits.size();
	endfunction

	function void flush();
		if (predicted_digits.size() != 0) begin
			$display("%0t: %0d digits never arrived, first expected digit %0d level_index %0d",
				$time, predicted_digits.size(), predicted_digits[0].digit,
				predicted_digits[0].level_index);
			errors += predicted_digits.size();
		end
	endfunction
endclass

module testbench;

	// An index no register answers to; writes there must change nothing.
	localparam logic [sgd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;
	// Room for the pipeline stages plus a full serializer to empty, with margin.
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 20;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	logic        hold_request  = 1'b0;
	int unsigned quiet_cycles  = 0;

	digit_checker board = new();

	sgd_cfg_if   cfg();
	sgd_coef_if  coef();
	sgd_digit_if result();

	signed_gadget_decompose dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef),
		.result (result)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls at the current rate, or one long hold-off when asked.
	// The hold is counted here so the sender keeps offering items meanwhile.
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Check every digit item taken from the block against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			board.check_digit(result.digit, result.level_index, result.last);
	end

	// Watchdog: give up after a long run of cycles where no channel moves an item.
	always @(posedge clk) begin
		if ((coef.valid && coef.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one coefficient, idling first at the current sender rate.
	// Leave valid high on return so back-to-back items need no extra edge.
	task automatic send_coefficient(logic [sgd_pkg::COEF_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			coef.valid <= 1'b0;
			@(posedge clk);
		end
		coef.valid       <= 1'b1;
		coef.coefficient <= value;
		do @(posedge clk); while (!coef.ready);
		board.note_coefficient(value);
	endtask

	// Drop valid and wait until every predicted digit has come out.
	task automatic drain();
		coef.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_reg(logic [sgd_pkg::CFG_IDX_W-1:0] index,
			logic [sgd_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(index, data);
	endtask

	// Reprogram only once the block is empty. Items under levels 0 leave no
	// digits behind, so also let the pipeline run out before writing.
	task automatic reconfigure(logic [sgd_pkg::CFG_DATA_W-1:0] bits_data,
			logic [sgd_pkg::CFG_DATA_W-1:0] levels_data);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_UNMAPPED, sgd_pkg::CFG_DATA_W'($urandom));
		write_reg(sgd_pkg::REG_DIGIT_BITS, bits_data);
		write_reg(sgd_pkg::REG_LEVELS, levels_data);
		cfg.valid <= 1'b0;
	endtask

	// Mostly uniform values, plus powers of two at and just below the rounding
	// boundaries and long runs of ones or zeros that push carries through.
	function automatic logic [sgd_pkg::COEF_W-1:0] pick_coefficient();
		logic [sgd_pkg::COEF_W-1:0] c;
		case ($urandom_range(3))
			0, 1: c = $urandom;
			2: c = (32'd1 << $urandom_range(31)) - $urandom_range(1);
			default: begin
				c = $urandom >> $urandom_range(31);
				if ($urandom_range(1))
					c = ~c;
			end
		endcase
		return c;
	endfunction

	initial begin
		logic [sgd_pkg::COEF_W-1:0]     corner_coefs [$];
		logic [sgd_pkg::CFG_DATA_W-1:0] phase_bits   [PHASES];
		logic [sgd_pkg::CFG_DATA_W-1:0] phase_levels [PHASES];
		int                             mode;

		// Reset settings: extremes, the rounding edge at bit 11 and both
		// sides of the half-base point of the top lane.
		corner_coefs = {32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_07FF, 32'h0000_0800, 32'h7FF0_0000, 32'h801F_F800, 32'hAAAA_AAAA};
		phase_bits   = '{8'd10, 8'd1, 8'd16, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0};
		phase_levels = '{8'd2, 8'd8, 8'd1, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0};

		cfg.valid        <= 1'b0;
		cfg.index        <= sgd_pkg::REG_DIGIT_BITS;
		cfg.data         <= '0;
		coef.valid       <= 1'b0;
		coef.coefficient <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling.
		foreach (corner_coefs[i])
			send_coefficient(corner_coefs[i]);

		// One-bit digits, one level: the half point sits at bit 31.
		reconfigure(8'd1, 8'd1);
		send_coefficient(32'h4000_0000);
		send_coefficient(32'hC000_0000);
		send_coefficient(32'h3FFF_FFFF);

		// Widest digits at full depth: no rounding, low lanes read zeros.
		reconfigure(8'd16, 8'd8);
		send_coefficient(32'hFFFF_FFFF);
		send_coefficient(32'h0000_8000);
		send_coefficient(32'h1234_5678);

		// Digit width 0 acts as 1; no levels gives no digits at all.
		reconfigure(8'd0, 8'd0);
		send_coefficient(32'hFFFF_FFFF);
		send_coefficient(32'h5555_5555);

		// Out-of-range fields clamp to 16 bits and MAX_LEVELS levels.
		reconfigure(8'hFF, 8'hFF);
		send_coefficient(32'h8000_7FFF);
		send_coefficient(32'h7FFF_8000);

		// 4 bits times 9 levels clamped to 8 gives exactly 32 bits: offset drops to zero.
		reconfigure(8'h24, 8'h09);
		send_coefficient(32'h8888_8888);
		send_coefficient(32'h7777_7777);

		// Random part: cycle through the idling modes over several settings.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 4)
				reconfigure(phase_bits[p], phase_levels[p]);
			else
				reconfigure({3'($urandom), 5'($urandom_range(16, 1))},
					{4'($urandom), 4'($urandom_range(8, 1))});
			mode = p % 4;
			send_idle_pct = (mode == 1) ? 80 : (mode == 3) ? 31 : 0;
			stall_pct     = (mode == 2) ? 80 : (mode == 3) ? 31 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Back the output up while items keep coming, so the input stalls.
				if (p == 0 && i == 4)
					hold_request <= 1'b1;
				// Let the block run dry in the middle of a phase once.
				if (p == 2 && i == PHASE_ITEMS / 2)
					drain();
				send_coefficient(pick_coefficient());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.flush();
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
